>>> design/hsd_pkg.sv
`timescale 1ns / 1ps

package hsd_pkg;

	// sector and table geometry
	localparam int SECTORS   = 6;
	localparam int NIB_W     = 4;
	localparam int SEC_W     = 3;
	localparam int WORD_W    = 32;
	localparam int CNT_W     = 4;
	localparam int KIND_W    = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 5;
	localparam int CFG_IDX_W = 2;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_DECODE    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CAL_START = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CAL_SAMPLE = 3'd3;
	localparam logic [KIND_W-1:0] KIND_INVERT    = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = 2'd1;

	// constants of the learner
	localparam logic [WORD_W-1:0] LEARN_BASE        = 32'h7000_0000;
	localparam logic [WORD_W-1:0] INIT_TABLE_RESET  = 32'h7465_2310;
	localparam logic [CNT_W-1:0]  THRESHOLD_RESET   = 4'd5;
	localparam logic [CNT_W-1:0]  COUNT_MAX         = 4'd10;
	localparam logic [SEC_W-1:0]  INDEX_FIRST       = 3'd1;
	localparam logic [SEC_W-1:0]  INDEX_END         = 3'd7;
	localparam logic [SEC_W-1:0]  SEC_NONE          = 3'd0;
	localparam logic [SEC_W-1:0]  SEC_ALL_HIGH      = 3'd7;

	typedef logic [SECTORS:1][NIB_W-1:0] table_t;

	// active table after reset, sectors 1..6
	localparam table_t ACTIVE_RESET = {4'd4, 4'd6, 4'd5, 4'd2, 4'd3, 4'd1};

endpackage

>>> design/hsd_if.sv
`timescale 1ns / 1ps

// sensor sample channel
interface hsd_in_if;
	logic                           valid;
	logic                           ready;
	logic [hsd_pkg::KIND_W-1:0]     kind;
	logic [hsd_pkg::SEC_W-1:0]      hall_state;

	modport source (output valid, output kind, output hall_state, input ready);
	modport sink (input valid, input kind, input hall_state, output ready);
endinterface

// result channel
interface hsd_out_if;
	logic                             valid;
	logic                             ready;
	logic [hsd_pkg::STATUS_W-1:0]     status;
	logic signed [hsd_pkg::POS_W-1:0] position;
	logic [hsd_pkg::WORD_W-1:0]       learned_word;

	modport source (output valid, output status, output position, output learned_word,
		input ready);
	modport sink (input valid, input status, input position, input learned_word,
		output ready);
endinterface

// configuration write channel
interface hsd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [hsd_pkg::CFG_IDX_W-1:0]   index;
	logic [hsd_pkg::WORD_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> design/hall_sector_decoder_learner.sv
`timescale 1ns / 1ps

// hall sensor sector decoder with a calibration learner
//
// samples: one transaction per item (kind, hall_state). results: one
// transaction per item (status, position, learned_word). cfg: register
// writes (index 0 initial_table, index 1 stable_threshold), always ready;
// writes to other indexes are dropped.
//
// an accepted item updates the table and learner registers and lands in the
// result register at the same edge. throughput is one item per cycle, set
// by the single result register; samples.ready stays high while that
// register is empty or being taken in the same cycle. when the receiver
// stalls, the result holds and samples.ready drops until it is taken.
//
// reset (arst_n low) restores the active table 1,3,2,5,6,4, the learned
// word 0x70000000, the learner counters and the configuration defaults,
// and empties the result register.
module hall_sector_decoder_learner (
	input  logic        clk,
	input  logic        arst_n,
	hsd_in_if.sink      samples,
	hsd_out_if.source   results,
	hsd_cfg_if.sink     cfg
);

	// configuration
	logic [hsd_pkg::WORD_W-1:0] init_table_q;
	logic [hsd_pkg::CNT_W-1:0]  threshold_q;

	// state
	hsd_pkg::table_t            active_q;
	logic [hsd_pkg::WORD_W-1:0] learned_q;
	logic [hsd_pkg::CNT_W-1:0]  count_q;
	logic [hsd_pkg::SEC_W-1:0]  cur_sec_q;
	logic [hsd_pkg::SEC_W-1:0]  last_sec_q;
	logic [hsd_pkg::SEC_W-1:0]  next_idx_q;

	// result register
	logic                             out_valid_q;
	logic [hsd_pkg::STATUS_W-1:0]     out_status_q;
	logic signed [hsd_pkg::POS_W-1:0] out_pos_q;
	logic [hsd_pkg::WORD_W-1:0]       out_word_q;

	logic accept;

	// next state
	hsd_pkg::table_t            active_nx;
	logic [hsd_pkg::WORD_W-1:0] learned_nx;
	logic [hsd_pkg::CNT_W-1:0]  count_nx;
	logic [hsd_pkg::SEC_W-1:0]  cur_sec_nx;
	logic [hsd_pkg::SEC_W-1:0]  last_sec_nx;
	logic [hsd_pkg::SEC_W-1:0]  next_idx_nx;
	logic [hsd_pkg::STATUS_W-1:0] status_nx;
	logic [hsd_pkg::POS_W-1:0]  pos_nx;

	logic                       sec_ok;
	logic [hsd_pkg::CNT_W-1:0]  count_sample;
	logic [hsd_pkg::WORD_W-1:0] invert_word;
	logic [hsd_pkg::SEC_W-1:0]  order_map [1:hsd_pkg::SECTORS];
	logic [hsd_pkg::SEC_W-1:0]  swap_map [1:hsd_pkg::SECTORS];

	assign accept        = samples.valid && samples.ready;
	assign samples.ready = !out_valid_q || results.ready;
	assign cfg.ready     = 1'b1;

	assign results.valid        = out_valid_q;
	assign results.status       = out_status_q;
	assign results.position     = out_pos_q;
	assign results.learned_word = out_word_q;

	assign sec_ok = (samples.hall_state != hsd_pkg::SEC_NONE) &&
		(samples.hall_state != hsd_pkg::SEC_ALL_HIGH);

	// debounce count for a calibration sample
	always_comb begin
		if (cur_sec_q == samples.hall_state) begin
			count_sample = (count_q < hsd_pkg::COUNT_MAX) ? count_q + 4'd1 : count_q;
		end else begin
			count_sample = '0;
		end
	end

	// reversed-direction learned word, later sector wins in the order map
	always_comb begin
		for (int v = 1; v <= hsd_pkg::SECTORS; v++) begin
			order_map[v] = '0;
			for (int k = 1; k <= hsd_pkg::SECTORS; k++) begin
				if (learned_q[4*k +: 4] == 4'(v)) begin
					order_map[v] = 3'(k);
				end
			end
		end
		swap_map[1] = order_map[1];
		swap_map[2] = order_map[6];
		swap_map[3] = order_map[5];
		swap_map[4] = order_map[4];
		swap_map[5] = order_map[3];
		swap_map[6] = order_map[2];
		invert_word = hsd_pkg::LEARN_BASE;
		for (int k = 1; k <= hsd_pkg::SECTORS; k++) begin
			invert_word = invert_word | (32'(k) << {swap_map[k], 2'b00});
		end
	end

	// item decode and state update
	always_comb begin
		active_nx   = active_q;
		learned_nx  = learned_q;
		count_nx    = count_q;
		cur_sec_nx  = cur_sec_q;
		last_sec_nx = last_sec_q;
		next_idx_nx = next_idx_q;
		status_nx   = hsd_pkg::ST_OK;
		pos_nx      = '0;
		unique case (samples.kind)
			hsd_pkg::KIND_DECODE: begin
				if (!sec_ok) begin
					status_nx = hsd_pkg::ST_BAD;
				end else begin
					pos_nx = {1'b0, active_q[samples.hall_state]} - 5'd1;
				end
			end
			hsd_pkg::KIND_LOAD: begin
				learned_nx = init_table_q;
				active_nx  = init_table_q[4*hsd_pkg::SECTORS+3:4];
			end
			hsd_pkg::KIND_CAL_START: begin
				if (!sec_ok) begin
					status_nx = hsd_pkg::ST_BAD;
				end else begin
					last_sec_nx = hsd_pkg::SEC_NONE;
					next_idx_nx = hsd_pkg::INDEX_FIRST;
					learned_nx  = hsd_pkg::LEARN_BASE;
					count_nx    = '0;
					cur_sec_nx  = samples.hall_state;
				end
			end
			hsd_pkg::KIND_CAL_SAMPLE: begin
				if (!sec_ok) begin
					status_nx = hsd_pkg::ST_BAD;
				end else begin
					count_nx   = count_sample;
					cur_sec_nx = samples.hall_state;
					status_nx  = hsd_pkg::ST_BUSY;
					if (!(count_sample < threshold_q) && samples.hall_state != last_sec_q) begin
						if (next_idx_q < hsd_pkg::INDEX_END) begin
							learned_nx  = learned_q |
								({29'd0, next_idx_q} << {samples.hall_state, 2'b00});
							next_idx_nx = next_idx_q + 3'd1;
							last_sec_nx = samples.hall_state;
						end else begin
							status_nx = hsd_pkg::ST_DONE;
						end
					end
				end
			end
			hsd_pkg::KIND_INVERT: begin
				active_nx  = learned_q[4*hsd_pkg::SECTORS+3:4];
				learned_nx = invert_word;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_table_q <= hsd_pkg::INIT_TABLE_RESET;
			threshold_q  <= hsd_pkg::THRESHOLD_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				hsd_pkg::REG_INITIAL_TABLE:    init_table_q <= cfg.data;
				hsd_pkg::REG_STABLE_THRESHOLD: threshold_q  <= cfg.data[hsd_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// table and learner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= hsd_pkg::ACTIVE_RESET;
			learned_q  <= hsd_pkg::LEARN_BASE;
			count_q    <= '0;
			cur_sec_q  <= hsd_pkg::SEC_NONE;
			last_sec_q <= hsd_pkg::SEC_NONE;
			next_idx_q <= hsd_pkg::INDEX_FIRST;
		end else if (accept) begin
			active_q   <= active_nx;
			learned_q  <= learned_nx;
			count_q    <= count_nx;
			cur_sec_q  <= cur_sec_nx;
			last_sec_q <= last_sec_nx;
			next_idx_q <= next_idx_nx;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_nx;
			out_pos_q    <= pos_nx;
			out_word_q   <= learned_nx;
		end
	end

`ifndef ASSERT_OFF
	// an invalid sensor code on decode is reported as such
	a_bad_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept && samples.kind == hsd_pkg::KIND_DECODE &&
		(samples.hall_state == hsd_pkg::SEC_NONE || samples.hall_state == hsd_pkg::SEC_ALL_HIGH)
		|=> results.valid && results.status == hsd_pkg::ST_BAD)
		else $error("invalid hall state not flagged on decode");

	// a nonzero position only comes with an ok status
	a_pos_ok: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.position != 5'sd0 |-> results.status == hsd_pkg::ST_OK)
		else $error("position driven on a non-ok result");

	// calibration start with a valid sector rewinds the learner
	a_cal_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && samples.kind == hsd_pkg::KIND_CAL_START && sec_ok
		|=> next_idx_q == hsd_pkg::INDEX_FIRST && count_q == '0 &&
			learned_q == hsd_pkg::LEARN_BASE)
		else $error("calibration start did not reset the learner");

	// debounce count saturates
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= hsd_pkg::COUNT_MAX)
		else $error("stable count above saturation");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// spare item kinds that the block leaves alone
	localparam logic [hsd_pkg::KIND_W-1:0] KIND_SPARE_LO = 3'd5;
	localparam logic [hsd_pkg::KIND_W-1:0] KIND_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [hsd_pkg::STATUS_W-1:0] status;
		logic [hsd_pkg::POS_W-1:0]    position;
		logic [hsd_pkg::WORD_W-1:0]   learned_word;
	} sector_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hsd_in_if  samples_if();
	hsd_out_if results_if();
	hsd_cfg_if cfg_if();

	hall_sector_decoder_learner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// shadow of the block state and its registers
	logic [hsd_pkg::NIB_W-1:0]  sector_order [1:hsd_pkg::SECTORS];
	logic [hsd_pkg::WORD_W-1:0] learned_shadow;
	logic [hsd_pkg::CNT_W-1:0]  stable_run;
	logic [hsd_pkg::SEC_W-1:0]  current_sec;
	logic [hsd_pkg::SEC_W-1:0]  last_learned_sec;
	logic [hsd_pkg::SEC_W-1:0]  next_order_idx;
	logic [hsd_pkg::WORD_W-1:0] table_reg;
	logic [hsd_pkg::CNT_W-1:0]  threshold_reg;

	sector_result_t pending_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_left = 0;
	int items_sent = 0;
	int results_checked = 0;
	int mismatches = 0;
	int completions = 0;
	int cycle_count = 0;

	// copy one packed table word into the sector order table
	function automatic void load_order(logic [hsd_pkg::WORD_W-1:0] word);
		for (int k = 1; k <= hsd_pkg::SECTORS; k++)
			sector_order[k] = word[4*k +: 4];
	endfunction

	// expected result of one transaction, advancing the shadow state
	function automatic sector_result_t predict_sector(logic [hsd_pkg::KIND_W-1:0] kind,
			logic [hsd_pkg::SEC_W-1:0] hall);
		sector_result_t r;
		logic ok;
		logic [hsd_pkg::SEC_W-1:0] order_map [0:7];
		logic [hsd_pkg::SEC_W-1:0] tmp;
		logic [hsd_pkg::NIB_W-1:0] v;
		r.status = hsd_pkg::ST_OK;
		r.position = '0;
		ok = (hall != hsd_pkg::SEC_NONE) && (hall != hsd_pkg::SEC_ALL_HIGH);
		case (kind)
			hsd_pkg::KIND_DECODE: begin
				if (!ok)
					r.status = hsd_pkg::ST_BAD;
				else
					r.position = {1'b0, sector_order[hall]} - 5'd1;
			end
			hsd_pkg::KIND_LOAD: begin
				learned_shadow = table_reg;
				load_order(table_reg);
			end
			hsd_pkg::KIND_CAL_START: begin
				if (!ok) begin
					r.status = hsd_pkg::ST_BAD;
				end else begin
					last_learned_sec = hsd_pkg::SEC_NONE;
					next_order_idx = hsd_pkg::INDEX_FIRST;
					learned_shadow = hsd_pkg::LEARN_BASE;
					stable_run = '0;
					current_sec = hall;
				end
			end
			hsd_pkg::KIND_CAL_SAMPLE: begin
				if (!ok) begin
					r.status = hsd_pkg::ST_BAD;
				end else begin
					// debounce: count repeats of the same sector
					if (current_sec == hall) begin
						if (stable_run < hsd_pkg::COUNT_MAX)
							stable_run = stable_run + 1'b1;
					end else begin
						stable_run = '0;
					end
					current_sec = hall;
					r.status = hsd_pkg::ST_BUSY;
					if (stable_run >= threshold_reg && hall != last_learned_sec) begin
						if (next_order_idx < hsd_pkg::INDEX_END) begin
							learned_shadow = learned_shadow |
								(hsd_pkg::WORD_W'(next_order_idx) << (4 * hall));
							next_order_idx = next_order_idx + 1'b1;
							last_learned_sec = hall;
						end else begin
							r.status = hsd_pkg::ST_DONE;
						end
					end
				end
			end
			hsd_pkg::KIND_INVERT: begin
				load_order(learned_shadow);
				for (int k = 0; k < 8; k++)
					order_map[k] = '0;
				for (int k = 1; k <= hsd_pkg::SECTORS; k++) begin
					v = sector_order[k];
					if (v >= 1 && v <= hsd_pkg::SECTORS)
						order_map[v] = k[hsd_pkg::SEC_W-1:0];
				end
				// reverse direction: swap mirrored order slots
				tmp = order_map[2]; order_map[2] = order_map[6]; order_map[6] = tmp;
				tmp = order_map[3]; order_map[3] = order_map[5]; order_map[5] = tmp;
				learned_shadow = hsd_pkg::LEARN_BASE;
				for (int k = 1; k <= hsd_pkg::SECTORS; k++)
					learned_shadow = learned_shadow |
						(hsd_pkg::WORD_W'(k) << (4 * order_map[k]));
			end
			default: ;
		endcase
		r.learned_word = learned_shadow;
		return r;
	endfunction

	function automatic void flag_mismatch(string field, logic [hsd_pkg::WORD_W-1:0] want,
			logic [hsd_pkg::WORD_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s of result %0d: expected %h, got %h",
				field, results_checked, want, got);
	endfunction

	// predict on accepted samples, then check accepted results
	always @(posedge clk) begin
		sector_result_t want;
		if (arst_n) begin
			if (samples_if.valid && samples_if.ready) begin
				want = predict_sector(samples_if.kind, samples_if.hall_state);
				if (want.status == hsd_pkg::ST_DONE)
					completions++;
				pending_results.push_back(want);
			end
			if (results_if.valid && results_if.ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("unrequested transaction, word", '0, results_if.learned_word);
				end else begin
					want = pending_results.pop_front();
					if (results_if.status !== want.status)
						flag_mismatch("status", want.status, results_if.status);
					if (results_if.position !== want.position)
						flag_mismatch("position", want.position, results_if.position);
					if (results_if.learned_word !== want.learned_word)
						flag_mismatch("learned_word", want.learned_word, results_if.learned_word);
				end
				results_checked++;
			end
		end
	end

	// receiver: random stalls plus long hold-offs on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			results_if.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else begin
			results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results pending",
				cycle_count, pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// offer one transaction and hold it until accepted
	task automatic send_item(logic [hsd_pkg::KIND_W-1:0] kind, logic [hsd_pkg::SEC_W-1:0] hall);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_if.valid = 1'b0;
			@(negedge clk);
		end
		samples_if.valid = 1'b1;
		samples_if.kind = kind;
		samples_if.hall_state = hall;
		do @(posedge clk); while (!samples_if.ready);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_noise();
		send_item(hsd_pkg::KIND_W'($urandom_range(0, 7)), hsd_pkg::SEC_W'($urandom_range(0, 7)));
	endtask

	// stop offering until every pending result has come back
	task automatic wait_drain();
		samples_if.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(logic [hsd_pkg::CFG_IDX_W-1:0] idx,
			logic [hsd_pkg::WORD_W-1:0] data);
		wait_drain();
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = data;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == hsd_pkg::REG_INITIAL_TABLE)
			table_reg = data;
		else if (idx == hsd_pkg::REG_STABLE_THRESHOLD)
			threshold_reg = data[hsd_pkg::CNT_W-1:0];
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	// decode of every sensor code plus the spare kinds, from reset state
	task automatic test_reset_decode();
		for (int h = 0; h < 8; h++)
			send_item(hsd_pkg::KIND_DECODE, hsd_pkg::SEC_W'(h));
		for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
			send_item(hsd_pkg::KIND_W'(k), hsd_pkg::SEC_W'($urandom_range(0, 7)));
	endtask

	// invalid codes on calibration, then load and invert
	task automatic test_invalid_and_ops();
		send_item(hsd_pkg::KIND_CAL_START, hsd_pkg::SEC_NONE);
		send_item(hsd_pkg::KIND_CAL_SAMPLE, hsd_pkg::SEC_ALL_HIGH);
		send_item(hsd_pkg::KIND_LOAD, hsd_pkg::SEC_ALL_HIGH);
		send_item(hsd_pkg::KIND_INVERT, hsd_pkg::SEC_NONE);
	endtask

	// table values 15 and 0 decode to the position extremes
	task automatic test_table_extremes();
		write_reg(hsd_pkg::REG_INITIAL_TABLE, 32'hF0F0_F0F0);
		send_item(hsd_pkg::KIND_LOAD, 3'd1);
		send_item(hsd_pkg::KIND_DECODE, 3'd1);
		send_item(hsd_pkg::KIND_DECODE, 3'd2);
	endtask

	// zero threshold accepts every sample at once
	task automatic test_threshold_zero();
		write_reg(hsd_pkg::REG_STABLE_THRESHOLD, 32'd0);
		send_item(hsd_pkg::KIND_CAL_START, 3'd3);
		send_item(hsd_pkg::KIND_CAL_SAMPLE, 3'd3);
		send_item(hsd_pkg::KIND_CAL_SAMPLE, 3'd5);
	endtask

	// long receiver hold-off while samples keep coming
	task automatic test_backpressure();
		stall_left = 250;
		repeat (40)
			send_item(hsd_pkg::KIND_CAL_SAMPLE,
				hsd_pkg::SEC_W'($urandom_range(1, hsd_pkg::SECTORS)));
		wait_drain();
	endtask

	task automatic reconfigure(int thresh);
		logic [hsd_pkg::WORD_W-1:0] word;
		if (thresh < 0) begin
			case ($urandom_range(0, 9))
				0: thresh = 0;
				1, 2, 3, 4, 5: thresh = $urandom_range(1, 3);
				6, 7: thresh = $urandom_range(4, 10);
				default: thresh = $urandom_range(11, 15);
			endcase
		end
		word = hsd_pkg::WORD_W'(thresh);
		if ($urandom_range(0, 2) == 0)
			word[hsd_pkg::WORD_W-1:hsd_pkg::CNT_W] =
				(hsd_pkg::WORD_W - hsd_pkg::CNT_W)'($urandom());
		write_reg(hsd_pkg::REG_STABLE_THRESHOLD, word);
		case ($urandom_range(0, 5))
			0: word = '0;
			1: word = '1;
			2: word = hsd_pkg::INIT_TABLE_RESET;
			default: word = $urandom();
		endcase
		write_reg(hsd_pkg::REG_INITIAL_TABLE, word);
	endtask

	// one calibration run: rotate through sectors, debounced, with some noise
	task automatic calib_sweep();
		logic [hsd_pkg::SEC_W-1:0] order [6];
		logic [hsd_pkg::SEC_W-1:0] tmp;
		logic [hsd_pkg::SEC_W-1:0] sec;
		int start, dir, steps, reps, thr, j;
		order = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};
		if ($urandom_range(0, 1)) begin
			for (int i = 5; i > 0; i--) begin
				j = $urandom_range(0, i);
				tmp = order[i]; order[i] = order[j]; order[j] = tmp;
			end
		end
		dir = $urandom_range(0, 1) ? 1 : 5;
		start = $urandom_range(0, 5);
		steps = $urandom_range(6, 9);
		thr = (threshold_reg > hsd_pkg::COUNT_MAX) ? 10 : int'(threshold_reg);
		if ($urandom_range(0, 4) == 0)
			send_item(hsd_pkg::KIND_LOAD, hsd_pkg::SEC_W'($urandom_range(0, 7)));
		else
			send_item(hsd_pkg::KIND_CAL_START, order[start]);
		for (int i = 0; i < steps; i++) begin
			sec = order[(start + dir * i) % 6];
			if ($urandom_range(0, 99) < 70)
				reps = thr + $urandom_range(0, 2);
			else
				reps = $urandom_range(1, thr + 1);
			if (reps > 11)
				reps = 11;
			for (int r = 0; r < reps; r++) begin
				if ($urandom_range(0, 99) < 6)
					send_noise();
				else
					send_item(hsd_pkg::KIND_CAL_SAMPLE, sec);
			end
		end
		if ($urandom_range(0, 99) < 60)
			send_item(hsd_pkg::KIND_INVERT, hsd_pkg::SEC_W'($urandom_range(0, 7)));
		repeat (8)
			send_item(hsd_pkg::KIND_DECODE, hsd_pkg::SEC_W'($urandom_range(0, 7)));
	endtask

	task automatic run_random_phase(int budget, int first_thresh);
		int goal;
		goal = items_sent + budget;
		reconfigure(first_thresh);
		while (items_sent < goal) begin
			if ($urandom_range(0, 99) < 20)
				reconfigure(-1);
			if ($urandom_range(0, 99) < 85)
				calib_sweep();
			else
				repeat (15) send_noise();
		end
	endtask

	initial begin
		samples_if.valid = 1'b0;
		samples_if.kind = hsd_pkg::KIND_DECODE;
		samples_if.hall_state = hsd_pkg::SEC_NONE;
		cfg_if.valid = 1'b0;
		cfg_if.index = hsd_pkg::REG_INITIAL_TABLE;
		cfg_if.data = '0;

		// shadow state after reset
		for (int k = 1; k <= hsd_pkg::SECTORS; k++)
			sector_order[k] = hsd_pkg::ACTIVE_RESET[k];
		learned_shadow = hsd_pkg::LEARN_BASE;
		stable_run = '0;
		current_sec = hsd_pkg::SEC_NONE;
		last_learned_sec = hsd_pkg::SEC_NONE;
		next_order_idx = hsd_pkg::INDEX_FIRST;
		table_reg = hsd_pkg::INIT_TABLE_RESET;
		threshold_reg = hsd_pkg::THRESHOLD_RESET;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_idle_pct = 32;
		recv_idle_pct = 71;
		test_reset_decode();
		test_invalid_and_ops();
		test_table_extremes();
		test_threshold_zero();
		test_backpressure();
		run_random_phase(460, 1);

		send_idle_pct = 71;
		recv_idle_pct = 32;
		run_random_phase(460, 10);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random_phase(460, 15);

		wait_drain();
		repeat (8) @(negedge clk);
		$display("covered %0d sensor transactions, %0d results checked, %0d mismatches",
			items_sent, results_checked, mismatches);
		$display("calibration reached completion %0d times across thresholds 0 to 15",
			completions);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
